@@ src/srw_pkg.sv @@
// shared types, constants and helper functions of the sine ripple warp address generator
package srw_pkg;

  localparam int COORD_W   = 10;
  localparam int SPAN_W    = 11;
  localparam int TICK_W    = 31;
  localparam int INDEX_W   = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = TICK_W;

  localparam int MAX_DIM      = 1024;
  localparam int SINE_ENTRIES = 8192;
  localparam int PHASE_W      = $clog2(SINE_ENTRIES);
  localparam int SWIRL_A      = SINE_ENTRIES / 64;
  localparam int SWIRL_B      = SINE_ENTRIES / 32;
  localparam int SWIRL_A_SHIFT = $clog2(SWIRL_A);
  localparam int SWIRL_B_SHIFT = $clog2(SWIRL_B);

  localparam int SPEED      = 40;
  localparam int SPEED_XA   = SPEED * 5;
  localparam int SPEED_XB   = SPEED * 4;
  localparam int SPEED_YA   = SPEED * 3;
  localparam int SPEED_YB   = SPEED * 4;
  localparam int OFFSET_XA  = 900;
  localparam int OFFSET_XB  = 300;
  localparam int OFFSET_YA  = 700;
  localparam int OFFSET_YB  = 1200;
  localparam int BASE_SHIFT = 128;

  // sum of coordinate, base shift and two terms stays within 124..1153
  localparam int SUM_W   = 11;
  localparam int SUM_MIN = BASE_SHIFT - 4;
  localparam int SUM_MAX = (1 << COORD_W) - 1 + BASE_SHIFT + 2;

  // first quarter index whose table entry reaches one half
  localparam int RIPPLE_LO = 683;
  localparam int RIPPLE_HI = SINE_ENTRIES / 2 - 1 - RIPPLE_LO;

  localparam int SPAN_RESET = 64;
  localparam int TICK_RESET = 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_SPAN  = 2'd0,
    REG_HEIGHT_SPAN = 2'd1,
    REG_TIME_TICK   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
  } coord_t;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [INDEX_W-1:0] src_index;
  } result_t;

  // floor(2 * sine / 65536) of the 16.16 table, as an SUM_W-bit two's complement value
  function automatic logic [SUM_W-1:0] sine_term(input logic [PHASE_W-1:0] phase);
    logic [PHASE_W-2:0] half_pos;
    logic big;
    logic [SUM_W-1:0] term;
    half_pos = phase[PHASE_W-2:0];
    big = (half_pos >= (PHASE_W-1)'(RIPPLE_LO)) && (half_pos <= (PHASE_W-1)'(RIPPLE_HI));
    case ({phase[PHASE_W-1], big})
      2'b00:   term = SUM_W'(0);
      2'b01:   term = SUM_W'(1);
      2'b10:   term = {SUM_W{1'b1}};
      2'b11:   term = {{(SUM_W-1){1'b1}}, 1'b0};
      default: term = SUM_W'(0);
    endcase
    return term;
  endfunction

  function automatic logic [SPAN_W-1:0] clamp_span(input logic [SPAN_W-1:0] span);
    logic [SPAN_W-1:0] eff;
    if (span == '0) begin
      eff = SPAN_W'(1);
    end else if (span > SPAN_W'(MAX_DIM)) begin
      eff = SPAN_W'(MAX_DIM);
    end else begin
      eff = span;
    end
    return eff;
  endfunction

endpackage

@@ src/srw_mod.sv @@
// pipelined remainder unit, one restoring compare and subtract step per stage
module srw_mod (
  input  logic                           clk,
  input  logic [srw_pkg::SUM_W-1:0]      value,
  input  logic [srw_pkg::SPAN_W-1:0]     span,
  output logic [srw_pkg::COORD_W-1:0]    rem
);

  localparam int STEPS = srw_pkg::SUM_W;
  localparam int CMP_W = srw_pkg::SUM_W + srw_pkg::SPAN_W;

  logic [srw_pkg::SUM_W-1:0] stage_in [STEPS];
  logic [srw_pkg::SUM_W-1:0] stage_q  [STEPS];

  assign stage_in[0] = value;

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [CMP_W-1:0] divisor;
    assign divisor = CMP_W'(span) << (STEPS - 1 - s);

    if (s > 0) begin : g_link
      assign stage_in[s] = stage_q[s-1];
    end

    always_ff @(posedge clk) begin
      if (CMP_W'(stage_in[s]) >= divisor) begin
        stage_q[s] <= stage_in[s] - srw_pkg::SUM_W'(divisor);
      end else begin
        stage_q[s] <= stage_in[s];
      end
    end
  end

  // remainder is below span, which is at most MAX_DIM
  assign rem = srw_pkg::COORD_W'(stage_q[STEPS-1]);

endmodule

@@ src/sine_ripple_warp_address_top.sv @@
// top level of the sine ripple warp address generator
//
//  channel   ports                               transaction when
//  input     start, busy, coord                  start high and busy low at the clock edge
//  result    done, result                        done high, held for that one cycle
//  config    cfg_write, cfg_index, cfg_data      cfg_write high at the clock edge
//
// one coordinate per cycle
// pipeline: input, phase and sum stages, 11 remainder stages, multiply and output stages
// rst clears the valid chain and loads spans of 64 and a tick of 0, no clearing pass
// busy stays low; the receiver takes every result, nothing stalls
module sine_ripple_warp_address_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  srw_pkg::coord_t                    coord,
  output logic                               done,
  output srw_pkg::result_t                   result,
  input  logic                               cfg_write,
  input  logic [srw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int LATENCY = 5 + srw_pkg::SUM_W;
  localparam int PROD_W  = srw_pkg::COORD_W + srw_pkg::SPAN_W;

  logic [srw_pkg::SPAN_W-1:0]  width_span;
  logic [srw_pkg::SPAN_W-1:0]  height_span;
  logic [srw_pkg::TICK_W-1:0]  time_tick;
  logic [srw_pkg::SPAN_W-1:0]  w_eff;
  logic [srw_pkg::SPAN_W-1:0]  h_eff;
  logic [srw_pkg::PHASE_W-1:0] tick_phase;
  logic [srw_pkg::PHASE_W-1:0] off_xa, off_xb, off_ya, off_yb;

  logic [LATENCY-1:0]          vld;
  logic                        accept;

  logic [srw_pkg::COORD_W-1:0] x1, y1, x2, y2;
  logic [srw_pkg::PHASE_W-1:0] ph_xa, ph_xb, ph_ya, ph_yb;
  logic [srw_pkg::SUM_W-1:0]   sx, sy;
  logic [srw_pkg::COORD_W-1:0] mod_x, mod_y;
  logic [srw_pkg::COORD_W-1:0] mx, my;
  logic [PROD_W-1:0]           prod;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_span  <= srw_pkg::SPAN_W'(srw_pkg::SPAN_RESET);
      height_span <= srw_pkg::SPAN_W'(srw_pkg::SPAN_RESET);
      time_tick   <= srw_pkg::TICK_W'(srw_pkg::TICK_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        srw_pkg::REG_WIDTH_SPAN:  width_span  <= cfg_data[srw_pkg::SPAN_W-1:0];
        srw_pkg::REG_HEIGHT_SPAN: height_span <= cfg_data[srw_pkg::SPAN_W-1:0];
        srw_pkg::REG_TIME_TICK:   time_tick   <= cfg_data[srw_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // only the tick modulo the table size reaches the phases
  assign tick_phase = time_tick[srw_pkg::PHASE_W-1:0];

  always_ff @(posedge clk) begin
    w_eff  <= srw_pkg::clamp_span(width_span);
    h_eff  <= srw_pkg::clamp_span(height_span);
    off_xa <= tick_phase * srw_pkg::PHASE_W'(srw_pkg::SPEED_XA)
              + srw_pkg::PHASE_W'(srw_pkg::OFFSET_XA);
    off_xb <= tick_phase * srw_pkg::PHASE_W'(srw_pkg::SPEED_XB)
              + srw_pkg::PHASE_W'(srw_pkg::OFFSET_XB);
    off_ya <= tick_phase * srw_pkg::PHASE_W'(srw_pkg::SPEED_YA)
              + srw_pkg::PHASE_W'(srw_pkg::OFFSET_YA);
    off_yb <= tick_phase * srw_pkg::PHASE_W'(srw_pkg::SPEED_YB)
              + srw_pkg::PHASE_W'(srw_pkg::OFFSET_YB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], accept};
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    x1 <= coord.dest_x;
    y1 <= coord.dest_y;
  end

  // phase stage
  always_ff @(posedge clk) begin
    x2    <= x1;
    y2    <= y1;
    ph_xa <= (srw_pkg::PHASE_W'(y1) << srw_pkg::SWIRL_A_SHIFT) + off_xa;
    ph_xb <= (srw_pkg::PHASE_W'(x1) << srw_pkg::SWIRL_B_SHIFT) + off_xb;
    ph_ya <= (srw_pkg::PHASE_W'(x1) << srw_pkg::SWIRL_A_SHIFT) + off_ya;
    ph_yb <= (srw_pkg::PHASE_W'(y1) << srw_pkg::SWIRL_B_SHIFT) + off_yb;
  end

  // ripple sum stage
  always_ff @(posedge clk) begin
    sx <= srw_pkg::SUM_W'(x2) + srw_pkg::SUM_W'(srw_pkg::BASE_SHIFT)
          + srw_pkg::sine_term(ph_xa) + srw_pkg::sine_term(ph_xb);
    sy <= srw_pkg::SUM_W'(y2) + srw_pkg::SUM_W'(srw_pkg::BASE_SHIFT)
          + srw_pkg::sine_term(ph_ya) + srw_pkg::sine_term(ph_yb);
  end

  srw_mod u_mod_x (
    .clk   (clk),
    .value (sx),
    .span  (w_eff),
    .rem   (mod_x)
  );

  srw_mod u_mod_y (
    .clk   (clk),
    .value (sy),
    .span  (h_eff),
    .rem   (mod_y)
  );

  // row offset stage
  always_ff @(posedge clk) begin
    mx   <= mod_x;
    my   <= mod_y;
    prod <= PROD_W'(mod_y) * PROD_W'(w_eff);
  end

  // output stage
  always_ff @(posedge clk) begin
    result.src_x     <= mx;
    result.src_y     <= my;
    result.src_index <= srw_pkg::INDEX_W'(prod + PROD_W'(mx));
  end

  assign done = vld[LATENCY-1];

`ifndef NO_ASSERTIONS
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done == $past(accept, LATENCY))
    else $error("result strobe does not match accepted transaction");

  a_sum_x_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (sx >= srw_pkg::SUM_W'(srw_pkg::SUM_MIN)
                && sx <= srw_pkg::SUM_W'(srw_pkg::SUM_MAX)))
    else $error("x ripple sum out of range");

  a_sum_y_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (sy >= srw_pkg::SUM_W'(srw_pkg::SUM_MIN)
                && sy <= srw_pkg::SUM_W'(srw_pkg::SUM_MAX)))
    else $error("y ripple sum out of range");
`endif

endmodule

@@ verif/warp_address_checker.sv @@
`timescale 1ns / 100ps
// checker that predicts each warped source address and compares it with the block's results
module warp_address_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  srw_pkg::coord_t                coord,
  input  logic                           done,
  input  srw_pkg::result_t               result,
  input  logic                           cfg_write,
  input  logic [srw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srw_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             in_flight,
  output int                             errors
);
  import srw_pkg::*;

  localparam int       TABLE_SIZE   = 8192;
  localparam bit [63:0] PI_FIX40    = 64'h3243F6A8886;
  localparam bit [63:0] ONE_FIX40   = 64'd1 << 40;
  localparam int       SPAN_CAP     = 1024;
  localparam int       ORIGIN_SHIFT = 128;
  localparam int       STEP_NARROW  = 128;
  localparam int       STEP_WIDE    = 256;
  localparam int       RATE_XA      = 200;
  localparam int       RATE_XB      = 160;
  localparam int       RATE_YA      = 120;
  localparam int       RATE_YB      = 160;
  localparam int       OFS_XA       = 900;
  localparam int       OFS_XB       = 300;
  localparam int       OFS_YA       = 700;
  localparam int       OFS_YB       = 1200;

  int unsigned taylor_div [8] = '{272, 210, 156, 110, 72, 42, 20, 6};
  int sine_table [TABLE_SIZE];

  logic [SPAN_W-1:0] width_cfg;
  logic [SPAN_W-1:0] height_cfg;
  logic [TICK_W-1:0] tick_cfg;
  result_t expected_src [$];
  int fail_count = 0;

  function automatic bit [63:0] fix40_product(input bit [63:0] a, input bit [63:0] b);
    return ((a * (b >> 20)) >> 20) + ((a * (b & 64'hFFFFF)) >> 40);
  endfunction

  // first quadrant of sine in 16.16 from a truncated taylor series in q40
  function automatic int quarter_wave(input int idx);
    bit [63:0] arg;
    bit [63:0] arg_sq;
    bit [63:0] acc;
    int k;
    arg = (64'(2 * idx + 1) * PI_FIX40) >> 13;
    arg_sq = fix40_product(arg, arg);
    acc = ONE_FIX40;
    for (k = 0; k < 8; k++) begin
      acc = ONE_FIX40 - fix40_product(arg_sq, acc) / 64'(taylor_div[k]);
    end
    return int'(fix40_product(arg, acc) >> 24);
  endfunction

  // floor(2 * sine / 65536)
  function automatic int ripple_step(input logic [12:0] phase);
    return (2 * sine_table[phase]) >>> 16;
  endfunction

  function automatic int effective_span(input logic [SPAN_W-1:0] s);
    if (s == '0) begin
      return 1;
    end else if (int'(s) > SPAN_CAP) begin
      return SPAN_CAP;
    end
    return int'(s);
  endfunction

  function automatic result_t predict_source(input coord_t c);
    bit [31:0] x;
    bit [31:0] y;
    bit [31:0] t;
    int w;
    int h;
    int sx;
    int sy;
    int wx;
    int wy;
    result_t r;
    x = 32'(c.dest_x);
    y = 32'(c.dest_y);
    t = 32'(tick_cfg);
    w = effective_span(width_cfg);
    h = effective_span(height_cfg);
    sx = int'(x) + ORIGIN_SHIFT
       + ripple_step(13'(y * STEP_NARROW + t * RATE_XA + OFS_XA))
       + ripple_step(13'(x * STEP_WIDE + t * RATE_XB + OFS_XB));
    sy = int'(y) + ORIGIN_SHIFT
       + ripple_step(13'(x * STEP_NARROW + t * RATE_YA + OFS_YA))
       + ripple_step(13'(y * STEP_WIDE + t * RATE_YB + OFS_YB));
    wx = sx % w;
    wy = sy % h;
    r.src_x = 10'(wx);
    r.src_y = 10'(wy);
    r.src_index = 20'(wy * w + wx);
    return r;
  endfunction

  initial begin
    int i;
    int v;
    for (i = 0; i < TABLE_SIZE / 4; i++) begin
      v = quarter_wave(i);
      sine_table[i] = v;
      sine_table[TABLE_SIZE / 2 - 1 - i] = v;
      sine_table[TABLE_SIZE / 2 + i] = -v;
      sine_table[TABLE_SIZE - 1 - i] = -v;
    end
  end

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      width_cfg = SPAN_W'(64);
      height_cfg = SPAN_W'(64);
      tick_cfg = '0;
      expected_src.delete();
    end else begin
      if (done) begin
        if (expected_src.size() == 0) begin
          $error("unexpected result: src_x %0d src_y %0d src_index %0d",
                 result.src_x, result.src_y, result.src_index);
          fail_count++;
        end else begin
          want = expected_src.pop_front();
          if (result.src_x !== want.src_x) begin
            $error("src_x: expected %0d, got %0d", want.src_x, result.src_x);
            fail_count++;
          end
          if (result.src_y !== want.src_y) begin
            $error("src_y: expected %0d, got %0d", want.src_y, result.src_y);
            fail_count++;
          end
          if (result.src_index !== want.src_index) begin
            $error("src_index: expected %0d, got %0d", want.src_index, result.src_index);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_src.push_back(predict_source(coord));
      end
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_WIDTH_SPAN:  width_cfg = cfg_data[SPAN_W-1:0];
          REG_HEIGHT_SPAN: height_cfg = cfg_data[SPAN_W-1:0];
          REG_TIME_TICK:   tick_cfg = cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
    end
    in_flight <= expected_src.size();
    errors <= fail_count;
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// testbench top: clock, reset, coordinate and register stimulus, and the final verdict
module testbench;
  import srw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 150;
  localparam int DRAIN_CYCLES  = 48;
  localparam int CYCLE_LIMIT   = 200000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  coord_t                coord = '0;
  logic                  done;
  result_t               result;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    in_flight;
  int                    errors;
  int                    cycle_count = 0;

  always #6 clk = ~clk;

  sine_ripple_warp_address_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .coord     (coord),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  warp_address_checker address_check (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .coord     (coord),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_flight (in_flight),
    .errors    (errors)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one coordinate transaction, after an optional pause with start low
  task automatic send_coord(input int x, input int y, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    coord <= '{dest_x: COORD_W'(x), dest_y: COORD_W'(y)};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [SPAN_W-1:0] w, input logic [SPAN_W-1:0] h,
                            input logic [TICK_W-1:0] t, input bit poke_unused);
    wait_idle();
    write_reg(REG_WIDTH_SPAN, CFG_DATA_W'(w));
    if (poke_unused) begin
      write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    end
    write_reg(REG_HEIGHT_SPAN, CFG_DATA_W'(h));
    write_reg(REG_TIME_TICK, t);
    cfg_write <= 1'b0;
  endtask

  function automatic int span_limit(input logic [SPAN_W-1:0] s);
    if (s == '0) begin
      return 1;
    end else if (int'(s) > MAX_DIM) begin
      return MAX_DIM;
    end
    return int'(s);
  endfunction

  function automatic logic [SPAN_W-1:0] pick_span();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return SPAN_W'(1);
      2:       return SPAN_W'(MAX_DIM);
      3:       return SPAN_W'($urandom_range(MAX_DIM + 1, 2047));
      4:       return SPAN_W'($urandom_range(1, 16));
      default: return SPAN_W'($urandom_range(1, MAX_DIM));
    endcase
  endfunction

  function automatic logic [TICK_W-1:0] pick_tick();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return TICK_W'($urandom_range(0, 255));
      default: return TICK_W'($urandom);
    endcase
  endfunction

  function automatic int pick_coord(input logic [SPAN_W-1:0] s);
    if ($urandom_range(0, 3) != 0) begin
      return $urandom_range(0, span_limit(s) - 1);
    end
    return $urandom_range(0, 1023);
  endfunction

  initial begin
    logic [SPAN_W-1:0] w;
    logic [SPAN_W-1:0] h;
    bit steady;
    int ph;
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset spans and tick
    send_coord(0, 0, 0);
    send_coord(63, 63, 0);
    send_coord(64, 64, 0);
    send_coord(1023, 1023, 0);
    send_coord(1023, 0, 0);
    send_coord(0, 1023, 0);

    // zero width, oversized height, largest tick, ignored register
    set_config('0, 11'd2047, '1, 1'b1);
    send_coord(0, 0, 0);
    send_coord(1023, 1023, 0);
    send_coord(512, 5, 0);

    set_config(11'd1024, 11'd1024, 31'h2AAAAAAA, 1'b0);
    send_coord(1023, 1023, 0);
    send_coord(0, 1023, 0);
    send_coord(1023, 0, 0);
    send_coord(341, 682, 0);

    set_config(11'd1, 11'd1, 31'd1, 1'b0);
    send_coord(0, 0, 0);
    send_coord(1023, 1023, 0);

    set_config(11'd1025, 11'd1000, 31'h55555555, 1'b1);
    send_coord(1023, 999, 0);
    send_coord(1000, 0, 0);

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      w = pick_span();
      h = pick_span();
      set_config(w, h, pick_tick(), $urandom_range(0, 3) == 0);
      steady = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_coord(pick_coord(w), pick_coord(h), steady ? 0 : $urandom_range(0, 10));
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
